### design/box3_pkg.sv
// box3_pkg: shared types, register indexes and reciprocal table for the 3x3 box blur.
// No dependencies; used by every box3_* module and by the top level.
package box3_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 8'd1;

    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 16;

    // 9 * 255 + rounding bias still fits in 12 bits
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 17;
    localparam int PROD_W      = SUM_W + RECIP_W;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

    // one line buffer entry: pixel of the row above and of the row two above
    typedef struct packed {
        t_rgb above;
        t_rgb two_above;
    } t_lines;

    // new window column, top to bottom
    typedef struct packed {
        t_rgb top;
        t_rgb mid;
        t_rgb bot;
    } t_column;

    // which neighbours of the center lie inside the frame
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } t_edge;

    typedef struct packed {
        logic [SUM_W-1:0] blue;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] red;
    } t_sum;

    // ceil(2^16 / cnt): exact for every rounded sum the window can produce
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        case (cnt)
            4'd1:    m = 17'd65536;
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd6:    m = 17'd10923;
            4'd9:    m = 17'd7282;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

endpackage

### design/box3_linebuf.sv
// box3_linebuf: two-row line buffer, one packed entry per column, registered read.
// Depends on box3_pkg (t_lines).
module box3_linebuf #(
    parameter int MAX_WIDTH = 2048,
    parameter int AW        = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  box3_pkg::t_lines      i_wr_data,
    output box3_pkg::t_lines      o_rd_data
);

    box3_pkg::t_lines r_mem [MAX_WIDTH];
    box3_pkg::t_lines r_rd_data;

    // a one-pixel-wide frame reads the column that is being written in the same cycle
    logic fwd;
    assign fwd = i_wr_en && (i_wr_addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= fwd ? i_wr_data : r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/box3_window.sv
// box3_window: 3x3 window columns and masked per-channel neighbourhood sums.
// Depends on box3_pkg (t_column, t_edge, t_sum).
module box3_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic                          i_emit,
    input  box3_pkg::t_column             i_col,
    input  box3_pkg::t_edge               i_edge,
    input  logic                          i_last,
    input  logic                          i_ready,
    output logic                          o_ready,
    output logic                          o_valid,
    output box3_pkg::t_sum                o_sum,
    output logic [box3_pkg::CNT_W-1:0]    o_cnt,
    output logic                          o_last
);

    box3_pkg::t_column r_wc1, r_wc2;
    logic r_valid;
    box3_pkg::t_sum r_sum;
    logic [box3_pkg::CNT_W-1:0] r_cnt;
    logic r_last;

    box3_pkg::t_sum n_sum;
    logic [box3_pkg::CNT_W-1:0] n_cnt;
    logic [1:0] rows, cols;

    always_comb begin
        box3_pkg::t_column win [3];
        logic rv [3];
        logic cv [3];
        box3_pkg::t_rgb p;
        win[0] = r_wc1;
        win[1] = r_wc2;
        win[2] = i_col;
        rv[0] = i_edge.top;
        rv[1] = 1'b1;
        rv[2] = i_edge.bottom;
        cv[0] = i_edge.left;
        cv[1] = 1'b1;
        cv[2] = i_edge.right;
        n_sum = '0;
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                case (i)
                    0:       p = win[j].top;
                    1:       p = win[j].mid;
                    default: p = win[j].bot;
                endcase
                if (rv[i] && cv[j]) begin
                    n_sum.red   = n_sum.red   + box3_pkg::SUM_W'(p.red);
                    n_sum.green = n_sum.green + box3_pkg::SUM_W'(p.green);
                    n_sum.blue  = n_sum.blue  + box3_pkg::SUM_W'(p.blue);
                end
            end
        end
        rows  = 2'd1 + 2'(i_edge.top) + 2'(i_edge.bottom);
        cols  = 2'd1 + 2'(i_edge.left) + 2'(i_edge.right);
        n_cnt = box3_pkg::CNT_W'(rows) * box3_pkg::CNT_W'(cols);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_wc1 <= r_wc2;
            r_wc2 <= i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && i_emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_emit) begin
            r_sum  <= n_sum;
            r_cnt  <= n_cnt;
            r_last <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_sum   = r_sum;
    assign o_cnt   = r_cnt;
    assign o_last  = r_last;

    // a held sum must not change while the divider stage is full
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_sum) && $stable(r_cnt))
        else $error("window sum changed while stalled");

    // the emitting load only happens when this stage has room
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load && i_emit |-> o_ready)
        else $error("window stage overwritten");

endmodule

### design/box3_divide.sv
// box3_divide: rounded division of the channel sums by the neighbour count, output register.
// Depends on box3_pkg (t_sum, t_rgb, recip).
module box3_divide (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  box3_pkg::t_sum                i_sum,
    input  logic [box3_pkg::CNT_W-1:0]    i_cnt,
    input  logic                          i_last,
    output logic                          o_ready,
    output logic                          o_valid,
    input  logic                          i_ready,
    output box3_pkg::t_rgb                o_rgb,
    output logic                          o_last
);

    logic r_valid;
    box3_pkg::t_rgb r_rgb;
    logic r_last;

    logic [box3_pkg::RECIP_W-1:0] m;
    logic [box3_pkg::SUM_W-1:0]   bias;
    logic [box3_pkg::PROD_W-1:0]  p_red, p_green, p_blue;
    logic                         take;

    assign m    = box3_pkg::recip(i_cnt);
    assign bias = box3_pkg::SUM_W'(i_cnt >> 1);

    // floor((sum + cnt/2) * ceil(2^16/cnt) / 2^16)
    assign p_red   = box3_pkg::PROD_W'(i_sum.red + bias) * box3_pkg::PROD_W'(m);
    assign p_green = box3_pkg::PROD_W'(i_sum.green + bias) * box3_pkg::PROD_W'(m);
    assign p_blue  = box3_pkg::PROD_W'(i_sum.blue + bias) * box3_pkg::PROD_W'(m);

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rgb.red   <= p_red[box3_pkg::RECIP_SHIFT +: 8];
            r_rgb.green <= p_green[box3_pkg::RECIP_SHIFT +: 8];
            r_rgb.blue  <= p_blue[box3_pkg::RECIP_SHIFT +: 8];
            r_last      <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_rgb   = r_rgb;
    assign o_last  = r_last;

    // the clipped neighbourhood always holds 1, 2, 3, 4, 6 or 9 pixels
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_cnt == 4'd1 || i_cnt == 4'd2 || i_cnt == 4'd3 ||
                     i_cnt == 4'd4 || i_cnt == 4'd6 || i_cnt == 4'd9))
        else $error("bad neighbour count");

endmodule

### design/box_blur_3x3_edge_clipped.sv
// Path: the word that releases a result goes through position logic, line buffer read,
// window sum and divide to the output register. Throughput: one word per cycle when the
// output is not stalled, set by the two-port line buffer and one-column-per-cycle window shift.
// Results lag the input by image_width+1 words; image_width+1 flush words drain a frame.
// Reset (i_rst_n low, synchronous) empties the pipeline, restores 640x480 and restarts
// the frame. The line buffer is not cleared; untouched entries only land outside the frame.
module box_blur_3x3_edge_clipped #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave side: tdata = {in_blue, in_green, in_red}, red in the low byte
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [23:0]                    i_s_axis_tdata,
    // tuser[0] = action (0 pixel, 1 flush)
    input  logic [0:0]                     i_s_axis_tuser,
    // master side: tdata = {out_blue, out_green, out_red}, red in the low byte
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [23:0]                    o_m_axis_tdata,
    // tlast = last_of_frame
    output logic                           o_m_axis_tlast,
    // register write port: index 0 image_width, 1 image_height
    input  logic                           i_cfg_we,
    input  logic [box3_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [box3_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RST_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int HW    = box3_pkg::HEIGHT_REG_W;

    // effective frame size, clipped when written
    logic [WW-1:0] r_w;
    logic [HW-1:0] r_h;

    // input side position, and count of processed words until the first result
    logic [AW-1:0] r_in_col, n_in_col;
    logic [HW-1:0] r_in_row, n_in_row;
    logic [WW-1:0] r_pos, n_pos;
    logic          r_primed, n_primed;
    // position of the next result
    logic [AW-1:0] r_out_col, n_out_col;
    logic [HW-1:0] r_out_row, n_out_row;

    // stage 1: word waiting for its line buffer read
    logic              r1_v;
    logic              r1_wr;
    logic [AW-1:0]     r1_addr;
    box3_pkg::t_rgb    r1_pix;
    logic              r1_emit;
    box3_pkg::t_edge   r1_edge;
    logic              r1_last;

    logic              accept, is_flush, in_frame, proc;
    logic              emit, last;
    box3_pkg::t_edge   edge_mask;
    logic [WW-1:0]     in_col_p1, out_col_p1;
    logic [HW:0]       out_row_p1;
    logic              s1_adv, s2_ready;
    logic [WW-1:0]     cfg_w;
    logic [HW-1:0]     cfg_h;

    box3_pkg::t_lines  rd_lines, wr_lines;
    box3_pkg::t_column col;

    box3_pkg::t_sum             s2_sum;
    logic [box3_pkg::CNT_W-1:0] s2_cnt;
    logic                       s2_valid, s2_last, s3_ready;
    box3_pkg::t_rgb             out_rgb;

    // ---------------------------------------------------------------- handshake
    assign s1_adv          = r1_v && (!r1_emit || s2_ready);
    assign o_s_axis_tready = !r1_v || s1_adv;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // flush words before the frame is complete are dropped; pixels after it act as flushes
    assign is_flush = i_s_axis_tuser[0];
    assign in_frame = r_in_row < r_h;
    assign proc     = accept && !(is_flush && in_frame);
    assign emit     = r_primed;

    // ---------------------------------------------------------------- positions
    assign in_col_p1  = WW'(r_in_col) + 1'b1;
    assign out_col_p1 = WW'(r_out_col) + 1'b1;
    assign out_row_p1 = {1'b0, r_out_row} + 1'b1;

    always_comb begin
        edge_mask.top    = (r_out_row != '0);
        edge_mask.bottom = (out_row_p1 < {1'b0, r_h});
        edge_mask.left   = (r_out_col != '0);
        edge_mask.right  = (out_col_p1 < r_w);
        last             = !edge_mask.bottom && !edge_mask.right;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_pos     = r_pos;
        n_primed  = r_primed;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (proc) begin
            if (in_col_p1 >= r_w) begin
                n_in_col = '0;
                if (in_frame) begin
                    n_in_row = r_in_row + 1'b1;
                end
            end else begin
                n_in_col = AW'(in_col_p1);
            end
            if (!r_primed) begin
                if (r_pos == r_w) begin
                    n_primed = 1'b1;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end else if (last) begin
                // bottom-right result: the next word starts a new frame
                n_in_col  = '0;
                n_in_row  = '0;
                n_pos     = '0;
                n_primed  = 1'b0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (out_col_p1 >= r_w) begin
                n_out_col = '0;
                n_out_row = r_out_row + 1'b1;
            end else begin
                n_out_col = AW'(out_col_p1);
            end
        end
    end

    // register values clipped as the frame logic uses them
    always_comb begin
        logic [box3_pkg::WIDTH_REG_W-1:0] wd;
        wd = i_cfg_wdata[box3_pkg::WIDTH_REG_W-1:0];
        if (wd == '0) begin
            cfg_w = WW'(1);
        end else if (32'(wd) > MAX_WIDTH) begin
            cfg_w = WW'(MAX_WIDTH);
        end else begin
            cfg_w = WW'(wd);
        end
        cfg_h = (i_cfg_wdata == '0) ? HW'(1) : i_cfg_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w       <= WW'(RST_W);
            r_h       <= HW'(480);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_pos     <= '0;
            r_primed  <= 1'b0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_cfg_we) begin
            // a write to a known register restarts the frame
            case (i_cfg_index)
                box3_pkg::CFG_IMAGE_WIDTH: begin
                    r_w       <= cfg_w;
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_pos     <= '0;
                    r_primed  <= 1'b0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end
                box3_pkg::CFG_IMAGE_HEIGHT: begin
                    r_h       <= cfg_h;
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_pos     <= '0;
                    r_primed  <= 1'b0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end
                default: begin
                end
            endcase
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_pos     <= n_pos;
            r_primed  <= n_primed;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // ---------------------------------------------------------------- stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (proc) begin
            r1_v <= 1'b1;
        end else if (s1_adv) begin
            r1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r1_wr   <= in_frame;
            r1_addr <= r_in_col;
            r1_pix  <= in_frame ? box3_pkg::t_rgb'(i_s_axis_tdata) : '0;
            r1_emit <= emit;
            r1_edge <= edge_mask;
            r1_last <= last;
        end
    end

    // line buffer: rows shift down by one as each in-frame pixel is written
    assign wr_lines.above     = r1_pix;
    assign wr_lines.two_above = rd_lines.above;

    box3_linebuf #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_linebuf (
        .i_clk     (i_clk),
        .i_rd_en   (proc),
        .i_rd_addr (r_in_col),
        .i_wr_en   (s1_adv && r1_wr),
        .i_wr_addr (r1_addr),
        .i_wr_data (wr_lines),
        .o_rd_data (rd_lines)
    );

    assign col.top = rd_lines.two_above;
    assign col.mid = rd_lines.above;
    assign col.bot = r1_pix;

    // ---------------------------------------------------------------- stage 2
    box3_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_adv),
        .i_emit  (r1_emit),
        .i_col   (col),
        .i_edge  (r1_edge),
        .i_last  (r1_last),
        .i_ready (s3_ready),
        .o_ready (s2_ready),
        .o_valid (s2_valid),
        .o_sum   (s2_sum),
        .o_cnt   (s2_cnt),
        .o_last  (s2_last)
    );

    // ---------------------------------------------------------------- stage 3
    box3_divide u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .i_sum   (s2_sum),
        .i_cnt   (s2_cnt),
        .i_last  (s2_last),
        .o_ready (s3_ready),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_rgb   (out_rgb),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = out_rgb;

    // ---------------------------------------------------------------- checks
    a_in_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_in_col) < r_w)
        else $error("input column beyond frame width");

    a_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_row <= r_h)
        else $error("input row beyond frame height");

    a_out_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WW'(r_out_col) < r_w) && (r_out_row < r_h))
        else $error("result position outside frame");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_v && !s1_adv |=> r1_v && $stable(r1_addr) && $stable(rd_lines))
        else $error("stage 1 word lost while stalled");

endmodule

### tb/box_blur_3x3_edge_clipped_test.sv
// Self-checking testbench for box_blur_3x3_edge_clipped: streams RGB frames, predicts each
// clipped 3x3 mean in a scoreboard class and checks every output word against it.
// Depends on box3_pkg and the box_blur_3x3_edge_clipped RTL only.
module box_blur_3x3_edge_clipped_test;
    import box3_pkg::*;

    localparam int MAX_W        = 2048;
    localparam int DRAIN_CYCLES = 8;      // pipeline is 3 deep; margin on top
    localparam int STALL_LIMIT  = 4000;   // cycles with no handshake at all
    localparam int RANDOM_WORDS = 550;

    // index that decodes to no register
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'hFF;

    // output stall patterns
    typedef enum logic [2:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_MOSTLY,
        RX_PERIODIC,
        RX_LONG_STALLS
    } rx_pattern_t;

    typedef struct packed {
        t_rgb pix;
        logic last;
    } blur_result_t;

    // Holds a bit-true copy of line buffers, window and raster positions; every accepted
    // input word is pushed through it and the resulting mean, if any, is queued.
    class blur_scoreboard;
        t_rgb                    line_above     [MAX_W];
        t_rgb                    line_two_above [MAX_W];
        t_rgb                    win [3][3];
        int unsigned             in_col, in_row, out_col, out_row;
        logic [WIDTH_REG_W-1:0]  width_reg;
        logic [HEIGHT_REG_W-1:0] height_reg;
        blur_result_t            expected_means [$];
        int                      errors;

        function new();
            foreach (line_above[k]) begin
                line_above[k]     = '0;
                line_two_above[k] = '0;
            end
            width_reg  = 12'd640;
            height_reg = 16'd480;
            errors     = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            foreach (win[i, j]) win[i][j] = '0;
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_W) return MAX_W;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_IMAGE_WIDTH) width_reg = val[WIDTH_REG_W-1:0];
            else if (idx == CFG_IMAGE_HEIGHT) height_reg = val[HEIGHT_REG_W-1:0];
            else return;
            restart_frame();
        endfunction

        function void take_word(logic flush, t_rgb px);
            int unsigned  w, h, pos, r, c, cnt, i, j;
            int unsigned  sum_r, sum_g, sum_b;
            logic         in_frame;
            t_rgb         pix, top, mid, v;
            blur_result_t res;

            w        = eff_width();
            h        = eff_height();
            in_frame = (in_row < h);
            // flush while the frame still wants pixels: dropped on the floor
            if (flush && in_frame) return;

            // past the end of the frame a pixel only pushes the pipe, data discarded
            pix = in_frame ? px : '0;
            top = '0;
            mid = '0;
            if (in_col < MAX_W) begin
                top = line_two_above[in_col];
                mid = line_above[in_col];
            end
            for (i = 0; i < 3; i++) begin
                win[i][0] = win[i][1];
                win[i][1] = win[i][2];
            end
            win[0][2] = top;
            win[1][2] = mid;
            win[2][2] = pix;
            if (in_frame && in_col < MAX_W) begin
                line_two_above[in_col] = mid;
                line_above[in_col]     = pix;
            end

            pos = in_row * w + in_col;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            // result lags by one row plus one pixel
            if (pos < w + 1) return;

            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            cnt   = 0;
            for (i = 0; i < 3; i++) begin
                r = out_row + i;
                if (r == 0 || r > h) continue;
                for (j = 0; j < 3; j++) begin
                    c = out_col + j;
                    if (c == 0 || c > w) continue;
                    v = win[i][j];
                    sum_r += v.red;
                    sum_g += v.green;
                    sum_b += v.blue;
                    cnt++;
                end
            end
            if (cnt == 0) cnt = 1;
            // round half up
            res.pix.red   = 8'((sum_r + cnt / 2) / cnt);
            res.pix.green = 8'((sum_g + cnt / 2) / cnt);
            res.pix.blue  = 8'((sum_b + cnt / 2) / cnt);
            res.last      = (out_row + 1 >= h) && (out_col + 1 >= w);
            expected_means.push_back(res);

            if (res.last) begin
                restart_frame();
            end else begin
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
            end
        endfunction

        function int pending();
            return expected_means.size();
        endfunction

        function void check_pixel(t_rgb got, logic got_last);
            blur_result_t want;
            if (expected_means.size() == 0) begin
                $error("output word with nothing expected: tdata %06h tlast %0b",
                       got, got_last);
                errors++;
                return;
            end
            want = expected_means.pop_front();
            if (got.red !== want.pix.red) begin
                $error("out_red: expected %0d, got %0d", want.pix.red, got.red);
                errors++;
            end
            if (got.green !== want.pix.green) begin
                $error("out_green: expected %0d, got %0d", want.pix.green, got.green);
                errors++;
            end
            if (got.blue !== want.pix.blue) begin
                $error("out_blue: expected %0d, got %0d", want.pix.blue, got.blue);
                errors++;
            end
            if (got_last !== want.last) begin
                $error("last_of_frame: expected %0b, got %0b", want.last, got_last);
                errors++;
            end
        endfunction
    endclass

    // ---------------------------------------------------------------- DUT hookup
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [23:0]           i_s_axis_tdata  = '0;   // red [7:0], green [15:8], blue [23:16]
    logic [0:0]            i_s_axis_tuser  = '0;   // action: 0 pixel, 1 flush
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [23:0]           o_m_axis_tdata;         // red [7:0], green [15:8], blue [23:16]
    logic                  o_m_axis_tlast;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata     = '0;

    box_blur_3x3_edge_clipped #(
        .MAX_WIDTH(MAX_W)
    ) DUT (
        .*
    );

    always #4 i_clk = ~i_clk;

    blur_scoreboard sb = new();

    int          words_sent  = 0;   // pixels and drain words, early flushes not counted
    int          burst_left  = 0;
    int          idle_cycles = 0;
    rx_pattern_t rx_mode     = RX_ALWAYS;
    int          rx_left     = 0;
    int          rx_tick     = 0;
    int          rx_hold     = 0;

    // ---------------------------------------------------------------- output side
    // The stall pattern is redrawn at random when its run ends; RX_ALWAYS gives
    // stretches with no backpressure at all.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = rx_pattern_t'($urandom_range(0, 4));
            rx_left = $urandom_range(30, 200);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_ALWAYS:   i_m_axis_tready = 1'b1;
            RX_COIN:     i_m_axis_tready = $urandom_range(0, 1);
            RX_MOSTLY:   i_m_axis_tready = ($urandom_range(0, 3) != 0);
            RX_PERIODIC: i_m_axis_tready = (rx_tick % 4 != 3);
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    i_m_axis_tready = 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    rx_hold = $urandom_range(4, 12);
                    i_m_axis_tready = 1'b0;
                end else begin
                    i_m_axis_tready = 1'b1;
                end
            end
        endcase
    end

    // Check output words and watch for a hang; both sample just after the rising edge,
    // before the design's registers move.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_pixel(t_rgb'(o_m_axis_tdata), o_m_axis_tlast);
            if ((o_m_axis_tvalid && i_m_axis_tready) || (i_s_axis_tvalid && o_s_axis_tready)
                    || i_cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    // ---------------------------------------------------------------- input side
    // All driving tasks are entered and left at a falling edge.

    function automatic logic [7:0] rand_channel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_rgb rand_pixel();
        t_rgb p;
        p.red   = rand_channel();
        p.green = rand_channel();
        p.blue  = rand_channel();
        return p;
    endfunction

    // one word on the slave side; bursts and gaps of random length
    task automatic send_word(logic flush, t_rgb px);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                i_s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid   = 1'b1;
        i_s_axis_tdata    = px;
        i_s_axis_tuser[0] = flush;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.take_word(flush, px);
        @(negedge i_clk);
    endtask

    // sender holds off until every expected word is out
    task automatic hold_until_drained();
        i_s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // idle before a register write: words with no result may still be in flight
    task automatic settle();
        i_s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] wv, logic [CFG_DATA_W-1:0] hv);
        settle();
        write_reg(CFG_IMAGE_WIDTH, wv);
        write_reg(CFG_IMAGE_HEIGHT, hv);
    endtask

    // One frame of w x h pixels plus w+1 drain words. cut > 0 stops after that many
    // pixels, leaving the frame unfinished. Noise: ignored flushes mid frame; drain words
    // are flushes or surplus pixels at random.
    task automatic send_frame(int unsigned w, int unsigned h, int unsigned cut);
        int unsigned total, k;
        total = w * h;
        if (cut != 0 && cut < total) total = cut;
        for (k = 0; k < total; k++) begin
            if ($urandom_range(0, 19) == 0) send_word(1'b1, rand_pixel());
            send_word(1'b0, rand_pixel());
            words_sent++;
            if ($urandom_range(0, 63) == 0) hold_until_drained();
        end
        if (cut != 0 && cut < w * h) return;
        for (k = 0; k <= w; k++) begin
            send_word(logic'($urandom_range(0, 1)), rand_pixel());
            words_sent++;
        end
    endtask

    // ---------------------------------------------------------------- main sequence
    initial begin
        int unsigned      k, w, h, frames, f, start_words;
        logic [CFG_DATA_W-1:0] wv, hv;
        t_rgb             px;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // 3x3 checkerboard of full-scale pixels: corners divide by 4, edges by 6,
        // center by 9; 510/4 lands exactly on a half and must round up. Width written
        // with junk in the unused upper bits.
        configure(16'hF003, 16'd3);
        for (k = 0; k < 9; k++) begin
            px = k[0] ? 24'h000000 : 24'hFFFFFF;
            if (k == 2) px = 24'h00FF80;
            send_word(1'b0, px);
            if (k == 3) send_word(1'b1, 24'hFFFFFF);   // flush mid frame, ignored
        end
        // drain: two flushes, then two surplus pixels whose data must be dropped
        send_word(1'b1, 24'h000000);
        send_word(1'b1, 24'hFFFFFF);
        send_word(1'b0, 24'hFFFFFF);
        send_word(1'b0, 24'hFFFFFF);

        // zero width and height behave as 1x1: result equals the pixel, marked last
        configure(16'd0, 16'd0);
        send_word(1'b0, 24'h807F01);
        send_word(1'b1, 24'h000000);
        send_word(1'b0, 24'hFFFFFF);

        // write to an unused index changes nothing
        settle();
        write_reg(CFG_UNUSED, 16'h0005);
        send_word(1'b0, 24'hFE01AA);
        send_word(1'b1, 24'h555555);
        send_word(1'b1, 24'hAAAAAA);

        // widest line: width register above the line buffer size clamps to MAX_W
        configure(16'hFFFF, 16'd2);
        send_frame(MAX_W, 2, 0);

        // tallest frame, cut short; the next register write restarts it
        configure(16'd2, 16'hFFFF);
        send_frame(2, 65535, 30);

        // random frame sizes, mostly small; some frames broken off early
        start_words = words_sent;
        while (words_sent - start_words < RANDOM_WORDS) begin
            case ($urandom_range(0, 9))
                0:       w = 0;
                1:       w = 1;
                2:       w = 2;
                3:       w = 3;
                8:       w = $urandom_range(13, 40);
                default: w = $urandom_range(4, 12);
            endcase
            case ($urandom_range(0, 5))
                0:       h = 0;
                1:       h = 1;
                2:       h = 2;
                default: h = $urandom_range(3, 8);
            endcase
            wv = {4'($urandom_range(0, 15)), 12'(w)};
            hv = 16'(h);
            configure(wv, hv);
            if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, 16'($urandom()));
            if (w == 0) w = 1;
            if (h == 0) h = 1;
            frames = $urandom_range(1, 3);
            for (f = 0; f < frames; f++) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_frame(w, h, $urandom_range(1, w * h));
                    break;
                end
                send_frame(w, h, 0);
            end
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
